// ===== sv/skin_tone_pixel_recolor_assert.svh =====
// assertion macros used by the skin recolor checker
`ifndef SKIN_TONE_PIXEL_RECOLOR_ASSERT_SVH
`define SKIN_TONE_PIXEL_RECOLOR_ASSERT_SVH

// concurrent check, quiet while reset is asserted
`define STP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// concurrent check that also holds during reset
`define STP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== sv/stp_pkg.sv =====
// shared types, constants and helpers of the skin recolor block
`timescale 1ns / 1ps
package stp_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned GainW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned YSumW   = 22;
  localparam int unsigned ProdW   = ChanW + GainW;
  localparam int unsigned FxShift = 14;

  // bt.601 luma weights, 14-bit fixed point
  localparam int unsigned YwB    = 1868;
  localparam int unsigned YwG    = 9617;
  localparam int unsigned YwR    = 4899;
  localparam int unsigned FxHalf = 8192;

  // chroma weights and offset (128 << 14 plus rounding half)
  localparam int unsigned CrW       = 11682;
  localparam int unsigned CbW       = 9241;
  localparam int unsigned ChromaOfs = 128 * 16384 + FxHalf;

  // reset gain is 1.0 in q1.8
  localparam logic [GainW-1:0] GainUnity = 9'd256;

  // skin boundary lines, cr scaled by 10000
  localparam logic signed [25:0] CrScale = 26'sd10000;
  localparam logic signed [25:0] LnAK = 26'sd15862;
  localparam logic signed [25:0] LnAC = 26'sd200000;
  localparam logic signed [25:0] LnBK = 26'sd3448;
  localparam logic signed [25:0] LnBC = 26'sd762069;
  localparam logic signed [25:0] LnCK = -26'sd45652;
  localparam logic signed [25:0] LnCC = 26'sd2345652;
  localparam logic signed [25:0] LnDK = -26'sd11500;
  localparam logic signed [25:0] LnDC = 26'sd3017500;
  localparam logic signed [25:0] LnEK = -26'sd22857;
  localparam logic signed [25:0] LnEC = 26'sd4328500;

  // simple thresholds of the skin rule
  localparam logic [ChanW-1:0] RedMin   = 8'd95;
  localparam logic [ChanW-1:0] GreenMin = 8'd40;
  localparam logic [ChanW-1:0] BlueMin  = 8'd20;
  localparam logic [ChanW-1:0] RgDiffMin = 8'd15;
  localparam logic [ChanW-1:0] LumaMin  = 8'd80;
  localparam logic [ChanW-1:0] CrMin    = 8'd135;
  localparam logic [ChanW-1:0] CbMin    = 8'd85;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlueGain  = 2'd0,
    CfgGreenGain = 2'd1,
    CfgRedGain   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] blue;
    logic [GainW-1:0] green;
    logic [GainW-1:0] red;
  } gain_t;

  // payload between the color conversion and the decision stage
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] scl_blue;
    logic [ChanW-1:0] scl_green;
    logic [ChanW-1:0] scl_red;
    logic [ChanW-1:0] cr;
    logic [ChanW-1:0] cb;
    logic             pre_ok;
  } ycc_t;

  // floor(c * gain / 256) saturated to 255
  function automatic logic [ChanW-1:0] sat_scale(input logic [ProdW-1:0] prod);
    logic [ChanW-1:0] res;
    if (prod[ProdW-1]) begin
      res = '1;
    end else begin
      res = prod[ProdW-2:ProdW-1-ChanW];
    end
    return res;
  endfunction

  // chroma term: clamp to 0 below, shift down, clamp to 255 above
  function automatic logic [ChanW-1:0] chroma_sat(input logic signed [24:0] t);
    logic [ChanW-1:0] res;
    if (t[24]) begin
      res = '0;
    end else if (|t[23:22]) begin
      res = '1;
    end else begin
      res = t[FxShift+ChanW-1:FxShift];
    end
    return res;
  endfunction

endpackage

// ===== sv/stp_if.sv =====
// valid/ready channels for incoming pixels and recolored pixels
`timescale 1ns / 1ps
interface stp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_blue;
  logic [7:0] pix_green;
  logic [7:0] pix_red;

  modport source (output valid, output pix_blue, output pix_green, output pix_red,
                  input ready);
  modport sink (input valid, input pix_blue, input pix_green, input pix_red,
                output ready);
endinterface

interface stp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       is_skin;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output is_skin, input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                input is_skin, output ready);
endinterface

// ===== sv/stp_ycc.sv =====
// two pipeline stages: luma sum and gain products, then chroma and simple rules
`timescale 1ns / 1ps
module stp_ycc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [stp_pkg::ChanW-1:0] pix_blue_i,
  input  logic [stp_pkg::ChanW-1:0] pix_green_i,
  input  logic [stp_pkg::ChanW-1:0] pix_red_i,
  input  stp_pkg::gain_t         gain_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output stp_pkg::ycc_t          out_o
);
  import stp_pkg::*;

  logic             v1_q, v2_q;
  logic             en1, en2;
  logic [ChanW-1:0] b1_q, g1_q, r1_q;
  logic [YSumW-1:0] ysum_d, ysum_q;
  logic [ProdW-1:0] pb_q, pg_q, pr_q;
  ycc_t             s2_d, s2_q;

  logic [ChanW-1:0]   y;
  logic signed [8:0]  dr, db;
  logic signed [24:0] tr, tb;
  logic [ChanW-1:0]   rg_diff;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: luma weighted sum
  assign ysum_d = YSumW'(pix_blue_i) * YSumW'(YwB) + YSumW'(pix_green_i) * YSumW'(YwG)
                + YSumW'(pix_red_i) * YSumW'(YwR) + YSumW'(FxHalf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      b1_q   <= pix_blue_i;
      g1_q   <= pix_green_i;
      r1_q   <= pix_red_i;
      ysum_q <= ysum_d;
      pb_q   <= ProdW'(pix_blue_i) * ProdW'(gain_i.blue);
      pg_q   <= ProdW'(pix_green_i) * ProdW'(gain_i.green);
      pr_q   <= ProdW'(pix_red_i) * ProdW'(gain_i.red);
    end
    if (en2) s2_q <= s2_d;
  end

  // stage 2: chroma, saturation of gain products, rgb rule
  always_comb begin
    y  = ysum_q[FxShift+ChanW-1:FxShift];
    dr = $signed({1'b0, r1_q}) - $signed({1'b0, y});
    db = $signed({1'b0, b1_q}) - $signed({1'b0, y});
    tr = $signed({{16{dr[8]}}, dr}) * $signed(25'(CrW)) + $signed(25'(ChromaOfs));
    tb = $signed({{16{db[8]}}, db}) * $signed(25'(CbW)) + $signed(25'(ChromaOfs));
    rg_diff = (r1_q >= g1_q) ? (r1_q - g1_q) : (g1_q - r1_q);

    s2_d.blue      = b1_q;
    s2_d.green     = g1_q;
    s2_d.red       = r1_q;
    s2_d.scl_blue  = sat_scale(pb_q);
    s2_d.scl_green = sat_scale(pg_q);
    s2_d.scl_red   = sat_scale(pr_q);
    s2_d.cr        = chroma_sat(tr);
    s2_d.cb        = chroma_sat(tb);
    s2_d.pre_ok    = (r1_q > RedMin) && (g1_q > GreenMin) && (b1_q > BlueMin)
                  && (r1_q > b1_q) && (rg_diff > RgDiffMin) && (y > LumaMin);
  end

  assign out_valid_o = v2_q;
  assign out_o       = s2_q;

endmodule

// ===== sv/stp_decide.sv =====
// last stage: chroma box and boundary lines, pixel select, output register
`timescale 1ns / 1ps
module stp_decide (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  stp_pkg::ycc_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [stp_pkg::ChanW-1:0] out_blue_o,
  output logic [stp_pkg::ChanW-1:0] out_green_o,
  output logic [stp_pkg::ChanW-1:0] out_red_o,
  output logic                      is_skin_o
);
  import stp_pkg::*;

  logic               v_q, en;
  logic signed [25:0] crs, cbs;
  logic               skin;
  logic [ChanW-1:0]   b_q, g_q, r_q;
  logic               skin_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    crs  = $signed(26'(in_i.cr)) * CrScale;
    cbs  = $signed(26'(in_i.cb));
    skin = in_i.pre_ok && (in_i.cr > CrMin) && (in_i.cb > CbMin)
        && (crs <= cbs * LnAK + LnAC)
        && (crs >= cbs * LnBK + LnBC)
        && (crs >= cbs * LnCK + LnCC)
        && (crs <= cbs * LnDK + LnDC)
        && (crs <= cbs * LnEK + LnEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skin_q <= skin;
      b_q    <= skin ? in_i.scl_blue  : in_i.blue;
      g_q    <= skin ? in_i.scl_green : in_i.green;
      r_q    <= skin ? in_i.scl_red   : in_i.red;
    end
  end

  assign out_valid_o = v_q;
  assign out_blue_o  = b_q;
  assign out_green_o = g_q;
  assign out_red_o   = r_q;
  assign is_skin_o   = skin_q;

endmodule

// ===== sv/skin_tone_pixel_recolor.sv =====
// top level of the skin tone pixel recolor block
`timescale 1ns / 1ps
// skin tone pixel recolor: takes one 8-bit bgr pixel per clock, converts it to
// y/cr/cb with 14-bit bt.601 fixed point weights, tests the rgb plus ycrcb skin
// rule (five cr/cb boundary lines compared exactly at a scale of 10000) and, for
// a skin pixel, scales each channel by its gain register, floor(c * gain / 256)
// saturated to 255; any other pixel passes unchanged. is_skin flags the match.
// throughput is one item per clock while the output is not stalled; an accepted
// item passes through three register stages (luma sum and gain products, chroma
// and rgb checks, boundary lines and output register). every stage has its own
// valid bit and loads whenever it is empty or drains, so bubbles close up and
// input is still taken while a finished item waits at the output.
// gains reset to 1.0 and are written through the cfg port: index 0 blue,
// 1 green, 2 red; index 3 is ignored. write gains only while no item is in flight.
module skin_tone_pixel_recolor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  stp_in_if.sink                      pix_in,
  stp_out_if.source                   pix_out,
  input  logic                        cfg_we_i,
  input  logic [stp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [stp_pkg::GainW-1:0]   cfg_wdata_i
);
  import stp_pkg::*;

  gain_t gain_q;
  logic  ycc_valid, ycc_ready;
  ycc_t  ycc;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q.blue  <= GainUnity;
      gain_q.green <= GainUnity;
      gain_q.red   <= GainUnity;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgBlueGain:  gain_q.blue  <= cfg_wdata_i;
        CfgGreenGain: gain_q.green <= cfg_wdata_i;
        CfgRedGain:   gain_q.red   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stages one and two: color conversion and gain products
  stp_ycc u_ycc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .pix_blue_i  (pix_in.pix_blue),
    .pix_green_i (pix_in.pix_green),
    .pix_red_i   (pix_in.pix_red),
    .gain_i      (gain_q),
    .out_valid_o (ycc_valid),
    .out_ready_i (ycc_ready),
    .out_o       (ycc)
  );

  // stage three: skin decision and output register
  stp_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ycc_valid),
    .in_ready_o  (ycc_ready),
    .in_i        (ycc),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .out_blue_o  (pix_out.out_blue),
    .out_green_o (pix_out.out_green),
    .out_red_o   (pix_out.out_red),
    .is_skin_o   (pix_out.is_skin)
  );

endmodule

// ===== sv/stp_checker.sv =====
// port level checks of the skin recolor block, bound to the top level
`timescale 1ns / 1ps
`include "skin_tone_pixel_recolor_assert.svh"
module stp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_blue_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_red_i,
  input logic       is_skin_i
);

  logic       in_acc, out_acc;
  logic [2:0] occ_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items inside the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_acc && !out_acc) begin
      occ_q <= occ_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      occ_q <= occ_q - 3'd1;
    end
  end

  `STP_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_blue_i) && $stable(out_green_i) && $stable(out_red_i) && $stable(is_skin_i), "output item changed while stalled")
  `STP_ASSERT(a_full_only, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i && occ_q == 3'd3, "input stalled with room in the pipeline")
  `STP_ASSERT(a_occ_max, clk_i, rst_ni, occ_q <= 3'd3, "more items in flight than stages")
  `STP_ASSERT_ALWAYS(a_out_has_item, clk_i, out_valid_i |-> occ_q != 3'd0, "output valid with no item in flight")

endmodule

bind skin_tone_pixel_recolor stp_checker u_stp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .out_blue_i  (pix_out.out_blue),
  .out_green_i (pix_out.out_green),
  .out_red_i   (pix_out.out_red),
  .is_skin_i   (pix_out.is_skin)
);

// ===== verif/stp_recolor_check_pkg.sv =====
// scoreboard class that predicts and checks recolored pixels
`timescale 1ns / 1ps
package stp_recolor_check_pkg;

  import stp_pkg::*;

  typedef struct {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             skin;
  } recolored_px_t;

  class recolor_scoreboard;

    logic [GainW-1:0] blue_gain;
    logic [GainW-1:0] green_gain;
    logic [GainW-1:0] red_gain;
    recolored_px_t    awaited_pixels[$];
    int unsigned      mismatches;

    function new();
      blue_gain   = GainUnity;
      green_gain  = GainUnity;
      red_gain    = GainUnity;
      mismatches  = 0;
    endfunction

    // unknown index leaves every gain alone
    function void set_gain(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] val);
      case (idx)
        CfgBlueGain:  blue_gain  = val;
        CfgGreenGain: green_gain = val;
        CfgRedGain:   red_gain   = val;
        default: ;
      endcase
    endfunction

    // rounded chroma, clamped to 0..255
    function int chroma_level(int diff, int weight);
      int acc;
      acc = diff * weight + 128 * 16384 + 8192;
      if (acc < 0) begin
        return 0;
      end
      acc = acc >>> 14;
      return (acc > 255) ? 255 : acc;
    endfunction

    function bit skin_match(int b, int g, int r);
      int luma;
      int cr;
      int cb;
      int cr_x;
      luma = (1868 * b + 9617 * g + 4899 * r + 8192) >>> 14;
      cr   = chroma_level(r - luma, 11682);
      cb   = chroma_level(b - luma, 9241);
      if (!(r > 95 && g > 40 && b > 20 && r > b && (r - g > 15 || g - r > 15))) begin
        return 1'b0;
      end
      if (!(cr > 135 && cb > 85 && luma > 80)) begin
        return 1'b0;
      end
      cr_x = 10000 * cr;
      return cr_x <= 15862 * cb + 200000 &&
             cr_x >= 3448 * cb + 762069 &&
             cr_x >= -45652 * cb + 2345652 &&
             cr_x <= -11500 * cb + 3017500 &&
             cr_x <= -22857 * cb + 4328500;
    endfunction

    // floor(c * gain / 256), saturated
    function logic [ChanW-1:0] apply_gain(logic [ChanW-1:0] c, logic [GainW-1:0] gain);
      int prod;
      prod = (int'(c) * int'(gain)) >>> 8;
      return (prod > 255) ? 8'd255 : prod[ChanW-1:0];
    endfunction

    function void note_pixel(logic [ChanW-1:0] b, logic [ChanW-1:0] g, logic [ChanW-1:0] r);
      recolored_px_t px;
      if (skin_match(int'(b), int'(g), int'(r))) begin
        px.blue  = apply_gain(b, blue_gain);
        px.green = apply_gain(g, green_gain);
        px.red   = apply_gain(r, red_gain);
        px.skin  = 1'b1;
      end else begin
        px.blue  = b;
        px.green = g;
        px.red   = r;
        px.skin  = 1'b0;
      end
      awaited_pixels.push_back(px);
    endfunction

    function void check_pixel(logic [ChanW-1:0] b, logic [ChanW-1:0] g, logic [ChanW-1:0] r,
                              logic skin);
      recolored_px_t px;
      if (awaited_pixels.size() == 0) begin
        $error("unexpected result item: out_blue %0d out_green %0d out_red %0d is_skin %0d",
               b, g, r, skin);
        mismatches++;
        return;
      end
      px = awaited_pixels.pop_front();
      if (b !== px.blue) begin
        $error("out_blue: expected %0d, actual %0d", px.blue, b);
        mismatches++;
      end
      if (g !== px.green) begin
        $error("out_green: expected %0d, actual %0d", px.green, g);
        mismatches++;
      end
      if (r !== px.red) begin
        $error("out_red: expected %0d, actual %0d", px.red, r);
        mismatches++;
      end
      if (skin !== px.skin) begin
        $error("is_skin: expected %0d, actual %0d", px.skin, skin);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited_pixels.size();
    endfunction

  endclass

endpackage

// ===== verif/tb_skin_tone_pixel_recolor.sv =====
// testbench for the skin tone pixel recolor block
`timescale 1ns / 1ps
module tb_skin_tone_pixel_recolor;

  import stp_pkg::*;
  import stp_recolor_check_pkg::*;

  localparam int ClkPeriod         = 8;
  localparam int NumPhases         = 8;
  localparam int RandItemsPerPhase = 129;
  localparam int TimeoutCycles     = 300000;
  // index with no register behind it, writes must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [GainW-1:0]   cfg_wdata;

  stp_in_if  pix_in_ch ();
  stp_out_if pix_out_ch ();

  recolor_scoreboard recolor_sb;
  int unsigned       results_seen = 0;
  int unsigned       burst_left   = 0;

  skin_tone_pixel_recolor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix_in_ch),
    .pix_out     (pix_out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // hard stop in case a handshake never completes
  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("FAIL");
    $finish;
  end

  // every accepted input item gets its expected result queued
  always @(posedge clk_i) begin
    if (rst_ni && pix_in_ch.valid && pix_in_ch.ready) begin
      recolor_sb.note_pixel(pix_in_ch.pix_blue, pix_in_ch.pix_green, pix_in_ch.pix_red);
    end
  end

  // every accepted result item is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pix_out_ch.valid && pix_out_ch.ready) begin
      recolor_sb.check_pixel(pix_out_ch.out_blue, pix_out_ch.out_green, pix_out_ch.out_red,
                             pix_out_ch.is_skin);
      results_seen++;
    end
  end

  // result side: segments of always-ready, coin-flip, mostly-stalled and
  // mostly-ready, plus two long hold-offs so the pipeline backs up into the input
  initial begin : result_sink
    int unsigned seg_len;
    int unsigned mode;
    int unsigned holds_done;
    int unsigned hold_cnt;
    holds_done = 0;
    pix_out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_done < 2 && results_seen >= ((holds_done == 0) ? 250 : 700)) begin
        pix_out_ch.ready = 1'b0;
        for (hold_cnt = 0; hold_cnt < 90; hold_cnt++) begin
          @(negedge clk_i);
        end
        holds_done++;
      end else begin
        seg_len = $urandom_range(8, 48);
        mode    = $urandom_range(0, 3);
        repeat (seg_len) begin
          case (mode)
            0: pix_out_ch.ready = 1'b1;
            1: pix_out_ch.ready = 1'($urandom_range(0, 1));
            2: pix_out_ch.ready = ($urandom_range(0, 3) == 0);
            default: pix_out_ch.ready = ($urandom_range(0, 3) != 0);
          endcase
          @(negedge clk_i);
        end
      end
    end
  end

  // tasks enter and leave at a falling edge

  // one config write, no handshake
  task automatic write_gain_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    recolor_sb.set_gain(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // offers one pixel; bursts of random length separated by random gaps
  task automatic offer_pixel(input logic [ChanW-1:0] b, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        pix_in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    pix_in_ch.valid     = 1'b1;
    pix_in_ch.pix_blue  = b;
    pix_in_ch.pix_green = g;
    pix_in_ch.pix_red   = r;
    do @(posedge clk_i); while (!pix_in_ch.ready);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every queued result has come back
  task automatic drain_pixels();
    pix_in_ch.valid = 1'b0;
    burst_left = 0;
    while (recolor_sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] clip_chan(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[ChanW-1:0];
  endfunction

  // mix of jitter around a known skin tone (hits the boundary lines often),
  // ranges that pass the rgb threshold checks, and fully random pixels
  task automatic gen_pixel(output logic [ChanW-1:0] b, output logic [ChanW-1:0] g,
                           output logic [ChanW-1:0] r);
    int unsigned pick;
    int          rv;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      b = clip_chan(120 + int'($urandom_range(0, 120)) - 60);
      g = clip_chan(150 + int'($urandom_range(0, 120)) - 60);
      r = clip_chan(200 + int'($urandom_range(0, 120)) - 60);
    end else if (pick < 65) begin
      rv = $urandom_range(96, 255);
      r  = rv[ChanW-1:0];
      g  = ChanW'($urandom_range(41, 255));
      b  = ChanW'($urandom_range(21, rv - 1));
    end else begin
      b = ChanW'($urandom_range(0, 255));
      g = ChanW'($urandom_range(0, 255));
      r = ChanW'($urandom_range(0, 255));
    end
  endtask

  // gain setting per phase: zero, all-ones (saturation), mixed, one tiny gain
  // with two near-unity, then random; phase 3 also pokes the unused index
  task automatic load_gains(input int unsigned phase_no);
    logic [GainW-1:0] bg;
    logic [GainW-1:0] gg;
    logic [GainW-1:0] rg;
    case (phase_no)
      1: begin bg = 9'd0;   gg = 9'd0;   rg = 9'd0;   end
      2: begin bg = 9'd511; gg = 9'd511; rg = 9'd511; end
      3: begin bg = 9'd256; gg = 9'd128; rg = 9'd384; end
      4: begin bg = 9'd1;   gg = 9'd255; rg = 9'd257; end
      default: begin
        bg = GainW'($urandom_range(0, 511));
        gg = GainW'($urandom_range(0, 511));
        rg = GainW'($urandom_range(0, 511));
      end
    endcase
    write_gain_reg(CfgBlueGain, bg);
    write_gain_reg(CfgGreenGain, gg);
    write_gain_reg(CfgRedGain, rg);
    if (phase_no == 3) begin
      write_gain_reg(CfgUnused, GainW'($urandom_range(0, 511)));
    end
  endtask

  initial begin : stimulus
    int unsigned      phase_no;
    int unsigned      item_no;
    logic [ChanW-1:0] pb;
    logic [ChanW-1:0] pg;
    logic [ChanW-1:0] pr;
    recolor_sb          = new();
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgBlueGain;
    cfg_wdata           = '0;
    pix_in_ch.valid     = 1'b0;
    pix_in_ch.pix_blue  = '0;
    pix_in_ch.pix_green = '0;
    pix_in_ch.pix_red   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items at reset gains (b, g, r order)
    offer_pixel(8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255);
    offer_pixel(8'd255, 8'd0, 8'd0);
    offer_pixel(8'd0, 8'd255, 8'd0);
    offer_pixel(8'd0, 8'd0, 8'd255);
    // typical skin tones
    offer_pixel(8'd120, 8'd150, 8'd200);
    offer_pixel(8'd150, 8'd180, 8'd230);
    offer_pixel(8'd200, 8'd220, 8'd254);
    // red threshold just below and at the pass side
    offer_pixel(8'd60, 8'd70, 8'd95);
    offer_pixel(8'd60, 8'd70, 8'd96);
    // green threshold
    offer_pixel(8'd60, 8'd40, 8'd150);
    offer_pixel(8'd60, 8'd41, 8'd150);
    // blue threshold
    offer_pixel(8'd20, 8'd80, 8'd150);
    offer_pixel(8'd21, 8'd80, 8'd150);
    // red equal to blue
    offer_pixel(8'd150, 8'd100, 8'd150);
    // red-green distance of 15 and 16
    offer_pixel(8'd100, 8'd185, 8'd200);
    offer_pixel(8'd100, 8'd184, 8'd200);
    // strong red, pale chroma, dark pixel
    offer_pixel(8'd30, 8'd60, 8'd250);
    offer_pixel(8'd90, 8'd100, 8'd110);
    offer_pixel(8'd25, 8'd45, 8'd100);

    // random phases, each with its own gain setting written while idle
    for (phase_no = 1; phase_no <= NumPhases; phase_no++) begin
      drain_pixels();
      load_gains(phase_no);
      for (item_no = 0; item_no < RandItemsPerPhase; item_no++) begin
        // one mid-phase pause until the pipeline is empty
        if (phase_no == 4 && item_no == 60) begin
          drain_pixels();
        end
        gen_pixel(pb, pg, pr);
        offer_pixel(pb, pg, pr);
      end
    end

    drain_pixels();
    // keep the clock running to catch any stray result item
    repeat (8) @(posedge clk_i);
    if (recolor_sb.mismatches == 0 && recolor_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
